[src/rrf_pkg.sv]
// Shared types and constants for the rounded rectangle fill span generator.
`default_nettype none
package rrf_pkg;

   // Largest corner radius accepted, and the coordinate grid size in bits.
   localparam int MAX_RADIUS  = 15;
   localparam int COORD_BITS  = 12;

   // Field widths fixed by the command and span formats.
   localparam int COORD_W     = 12;
   localparam int RAD_W       = 4;
   localparam int COLOR_W     = 32;

   // Grid is capped so every coordinate fits the 12-bit span fields.
   localparam int GRID        = (COORD_BITS < 12) ? (1 << COORD_BITS) : 4096;
   localparam int SUM_W       = COORD_W + 1;

   // Midpoint decision value range stays well inside this signed width.
   localparam int DEC_W       = RAD_W + 4;

   // Front-to-back command queue.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Classified command handed from the front to the back.
   typedef struct packed {
      logic               bad;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] w;
      logic [COORD_W-1:0] yu;
      logic [COORD_W-1:0] mid_h;
      logic [COORD_W-1:0] xl;
      logic [COORD_W-1:0] yb;
      logic [COORD_W-1:0] wm;
      logic [RAD_W-1:0]   radius;
      logic [COLOR_W-1:0] color;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_MIDDLE,
      BK_ARC
   } back_state_type;

endpackage
`default_nettype wire

[src/rrf_front.sv]
// Front end: takes fill commands, checks the shape and precomputes span bases.
`default_nettype none
module rrf_front
   import rrf_pkg::*;
(
   input  wire logic               req_push,
   output logic                    req_full,
   input  wire logic [COORD_W-1:0] req_rect_x,
   input  wire logic [COORD_W-1:0] req_rect_y,
   input  wire logic [COORD_W-1:0] req_rect_w,
   input  wire logic [COORD_W-1:0] req_rect_h,
   input  wire logic [RAD_W-1:0]   req_corner_radius,
   input  wire logic [COLOR_W-1:0] req_fill_color,
   input  wire q_status_type       q_status,
   output logic                    q_push,
   output cmd_type                 q_cmd
);

   logic [COORD_W-1:0] r_ext;
   logic [COORD_W-1:0] r2_ext;
   logic [SUM_W-1:0]   x_end;
   logic [SUM_W-1:0]   y_end;
   logic               bad;

   assign req_full = q_status.full;
   assign q_push   = req_push && !q_status.full;

   always_comb begin
      r_ext  = COORD_W'(req_corner_radius);
      r2_ext = COORD_W'({req_corner_radius, 1'b0});
      x_end  = SUM_W'(req_rect_x) + SUM_W'(req_rect_w);
      y_end  = SUM_W'(req_rect_y) + SUM_W'(req_rect_h);
      bad    = (req_corner_radius > RAD_W'(MAX_RADIUS))
            || (req_rect_w < r2_ext)
            || (req_rect_h < r2_ext)
            || (SUM_W'(req_rect_x) >= SUM_W'(GRID))
            || (SUM_W'(req_rect_y) >= SUM_W'(GRID))
            || (x_end > SUM_W'(GRID))
            || (y_end > SUM_W'(GRID))
            || (y_end < (SUM_W'(req_corner_radius) + SUM_W'(1)));

      q_cmd.bad    = bad;
      q_cmd.x      = req_rect_x;
      q_cmd.w      = req_rect_w;
      q_cmd.yu     = req_rect_y + r_ext;
      q_cmd.mid_h  = req_rect_h - r2_ext;
      q_cmd.xl     = req_rect_x + r_ext;
      q_cmd.yb     = req_rect_y + req_rect_h - r_ext - COORD_W'(1);
      q_cmd.wm     = req_rect_w - r2_ext;
      q_cmd.radius = req_corner_radius;
      q_cmd.color  = req_fill_color;
   end

endmodule
`default_nettype wire

[src/rrf_queue.sv]
// Short command queue between the front end and the span sequencer.
`default_nettype none
module rrf_queue
   import rrf_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_cmd,
   input  wire logic    pop,
   output cmd_type      head_cmd,
   output q_status_type status
);

   cmd_type            entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff;
   logic [QPTR_W-1:0]  wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff;
   logic [QPTR_W-1:0]  rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff;
   logic [QCNT_W-1:0]  count_in;
   logic               do_push;
   logic               do_pop;

   assign status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head_cmd     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule
`default_nettype wire

[src/rrf_back.sv]
// Back end: walks the midpoint circle, one span per cycle unless stalled.
`default_nettype none
module rrf_back
   import rrf_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cmd_type             head_cmd,
   input  wire q_status_type        q_status,
   output logic                     q_pop,
   output logic                     rsp_empty,
   input  wire logic                rsp_pop,
   output logic [COORD_W-1:0]       rsp_span_x,
   output logic [COORD_W-1:0]       rsp_span_y,
   output logic [COORD_W-1:0]       rsp_span_w,
   output logic [COORD_W-1:0]       rsp_span_h,
   output logic [COLOR_W-1:0]       rsp_span_color,
   output logic                     rsp_last,
   output logic                     rsp_bad_shape
);

   back_state_type            state_ff;
   back_state_type            state_in;
   cmd_type                   cmd_ff;
   cmd_type                   cmd_in;
   logic [RAD_W-1:0]          px_ff;
   logic [RAD_W-1:0]          px_in;
   logic [RAD_W-1:0]          py_ff;
   logic [RAD_W-1:0]          py_in;
   logic signed [DEC_W-1:0]   d_ff;
   logic signed [DEC_W-1:0]   d_in;
   logic [1:0]                quad_ff;
   logic [1:0]                quad_in;

   logic                      out_valid_ff;
   logic                      out_valid_in;
   logic [COORD_W-1:0]        out_x_ff;
   logic [COORD_W-1:0]        out_x_in;
   logic [COORD_W-1:0]        out_y_ff;
   logic [COORD_W-1:0]        out_y_in;
   logic [COORD_W-1:0]        out_w_ff;
   logic [COORD_W-1:0]        out_w_in;
   logic [COORD_W-1:0]        out_h_ff;
   logic [COORD_W-1:0]        out_h_in;
   logic [COLOR_W-1:0]        out_color_ff;
   logic [COLOR_W-1:0]        out_color_in;
   logic                      out_last_ff;
   logic                      out_last_in;
   logic                      out_bad_ff;
   logic                      out_bad_in;

   logic                      advance;
   logic                      emit;
   logic [RAD_W-1:0]          off_a;
   logic [RAD_W-1:0]          off_b;
   logic signed [DEC_W-1:0]   d_inc;

   assign advance = !out_valid_ff || rsp_pop;

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      d_in         = d_ff;
      quad_in      = quad_ff;
      q_pop        = 1'b0;
      emit         = 1'b0;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      out_w_in     = out_w_ff;
      out_h_in     = out_h_ff;
      out_color_in = out_color_ff;
      out_last_in  = out_last_ff;
      out_bad_in   = out_bad_ff;

      // Quadrant pairs 0/1 offset x by py, pairs 2/3 by px.
      off_a = quad_ff[1] ? px_ff : py_ff;
      off_b = quad_ff[1] ? py_ff : px_ff;
      if (d_ff[DEC_W-1]) begin
         d_inc = DEC_W'({px_ff, 1'b1});
      end else begin
         d_inc = DEC_W'({px_ff, 1'b1}) - DEC_W'({py_ff, 1'b0});
      end

      unique case (state_ff)
         BK_IDLE: begin
            if (!q_status.empty) begin
               q_pop    = 1'b1;
               cmd_in   = head_cmd;
               px_in    = '0;
               py_in    = head_cmd.radius;
               d_in     = DEC_W'(1) - DEC_W'(head_cmd.radius);
               quad_in  = '0;
               state_in = BK_MIDDLE;
            end
         end
         BK_MIDDLE: begin
            if (advance) begin
               emit = 1'b1;
               if (cmd_ff.bad) begin
                  out_x_in     = '0;
                  out_y_in     = '0;
                  out_w_in     = '0;
                  out_h_in     = '0;
                  out_color_in = '0;
                  out_last_in  = 1'b1;
                  out_bad_in   = 1'b1;
                  state_in     = BK_IDLE;
               end else begin
                  out_x_in     = cmd_ff.x;
                  out_y_in     = cmd_ff.yu;
                  out_w_in     = cmd_ff.w;
                  out_h_in     = cmd_ff.mid_h;
                  out_color_in = cmd_ff.color;
                  out_last_in  = 1'b0;
                  out_bad_in   = 1'b0;
                  state_in     = BK_ARC;
               end
            end
         end
         BK_ARC: begin
            if (advance) begin
               emit         = 1'b1;
               out_x_in     = cmd_ff.xl - COORD_W'(off_a);
               out_w_in     = cmd_ff.wm + COORD_W'({off_a, 1'b0});
               out_y_in     = quad_ff[0] ? (cmd_ff.yb + COORD_W'(off_b))
                                         : (cmd_ff.yu - COORD_W'(off_b));
               out_h_in     = COORD_W'(1);
               out_color_in = cmd_ff.color;
               out_bad_in   = 1'b0;
               out_last_in  = 1'b0;
               quad_in      = quad_ff + 2'd1;
               if (quad_ff == 2'd3) begin
                  if (px_ff < py_ff) begin
                     // Step the midpoint loop from the pre-step px and py.
                     d_in  = d_ff + d_inc;
                     px_in = px_ff + RAD_W'(1);
                     if (!d_ff[DEC_W-1]) begin
                        py_in = py_ff - RAD_W'(1);
                     end
                  end else begin
                     out_last_in = 1'b1;
                     state_in    = BK_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase

      if (emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      px_ff        <= px_in;
      py_ff        <= py_in;
      d_ff         <= d_in;
      quad_ff      <= quad_in;
      out_x_ff     <= out_x_in;
      out_y_ff     <= out_y_in;
      out_w_ff     <= out_w_in;
      out_h_ff     <= out_h_in;
      out_color_ff <= out_color_in;
      out_last_ff  <= out_last_in;
      out_bad_ff   <= out_bad_in;
   end

   assign rsp_empty      = !out_valid_ff;
   assign rsp_span_x     = out_x_ff;
   assign rsp_span_y     = out_y_ff;
   assign rsp_span_w     = out_w_ff;
   assign rsp_span_h     = out_h_ff;
   assign rsp_span_color = out_color_ff;
   assign rsp_last       = out_last_ff;
   assign rsp_bad_shape  = out_bad_ff;

endmodule
`default_nettype wire

[src/rounded_rect_fill_spans.sv]
// Top level of the rounded rectangle fill span generator.
// A command passes the queue, the sequencer's command register and the result register
// before its first span shows on rsp_. It holds the sequencer for its spans (5 to 49), a
// rejected shape for its one span. The arc sequencer gives one span per cycle unless stalled.
// Up to two commands wait in the queue while the sequencer works.
// Reset (synchronous, active high) empties the queue and the result register.
`default_nettype none
module rounded_rect_fill_spans
   import rrf_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   // Command channel
   input  wire logic               req_push,
   output logic                    req_full,
   input  wire logic [COORD_W-1:0] req_rect_x,
   input  wire logic [COORD_W-1:0] req_rect_y,
   input  wire logic [COORD_W-1:0] req_rect_w,
   input  wire logic [COORD_W-1:0] req_rect_h,
   input  wire logic [RAD_W-1:0]   req_corner_radius,
   input  wire logic [COLOR_W-1:0] req_fill_color,
   // Span channel
   output logic                    rsp_empty,
   input  wire logic               rsp_pop,
   output logic [COORD_W-1:0]      rsp_span_x,
   output logic [COORD_W-1:0]      rsp_span_y,
   output logic [COORD_W-1:0]      rsp_span_w,
   output logic [COORD_W-1:0]      rsp_span_h,
   output logic [COLOR_W-1:0]      rsp_span_color,
   output logic                    rsp_last,
   output logic                    rsp_bad_shape
);

   // Front-to-back handoff: the front classifies a command in the cycle of its
   // transfer and the queue captures it together with the precomputed bases.
   q_status_type q_status;
   logic         q_push;
   logic         q_pop;
   cmd_type      push_cmd;
   cmd_type      head_cmd;

   // Classify: range and grid checks plus the arc base coordinates.
   rrf_front u_front (
      .req_push          (req_push),
      .req_full          (req_full),
      .req_rect_x        (req_rect_x),
      .req_rect_y        (req_rect_y),
      .req_rect_w        (req_rect_w),
      .req_rect_h        (req_rect_h),
      .req_corner_radius (req_corner_radius),
      .req_fill_color    (req_fill_color),
      .q_status          (q_status),
      .q_push            (q_push),
      .q_cmd             (push_cmd)
   );

   // Decouple: the front keeps taking commands while the back drains spans.
   rrf_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .pop      (q_pop),
      .head_cmd (head_cmd),
      .status   (q_status)
   );

   // Sequence: middle band and four arc rows per midpoint step, or one error result
   // for a rejected shape, into a result register that advances when empty or popped.
   rrf_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_cmd       (head_cmd),
      .q_status       (q_status),
      .q_pop          (q_pop),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_span_x     (rsp_span_x),
      .rsp_span_y     (rsp_span_y),
      .rsp_span_w     (rsp_span_w),
      .rsp_span_h     (rsp_span_h),
      .rsp_span_color (rsp_span_color),
      .rsp_last       (rsp_last),
      .rsp_bad_shape  (rsp_bad_shape)
   );

`ifndef SYNTHESIS
   // A rejected shape is always the single, final result of its command.
   a_bad_is_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_bad_shape) |-> rsp_last)
      else $error("bad_shape result without last");

   // The error result carries zeroed geometry and color.
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_bad_shape) |->
         (rsp_span_w == '0 && rsp_span_h == '0 && rsp_span_color == '0))
      else $error("bad_shape result with nonzero payload");

   // The queue never reports full and empty at once.
   a_queue_status: assert property (@(posedge clock) disable iff (reset)
      !(q_status.full && q_status.empty))
      else $error("queue full and empty together");

   // Reset leaves no result waiting.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> rsp_empty)
      else $error("result pending after reset");
`endif

endmodule
`default_nettype wire

[verif/tb_top.sv]
// Testbench for the rounded rectangle fill span generator: directed table, random commands.
module tb_top
   import rrf_pkg::*;
();

   // One fill command as it crosses the req_ channel.
   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] w;
      logic [COORD_W-1:0] h;
      logic [RAD_W-1:0]   r;
      logic [COLOR_W-1:0] color;
   } fill_cmd_type;

   // One span as it crosses the rsp_ channel.
   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] w;
      logic [COORD_W-1:0] h;
      logic [COLOR_W-1:0] color;
      logic               last;
      logic               bad;
   } span_type;

   // How the first span of a directed row is known: from the span model only,
   // or typed into the table as a rejected shape or as the middle band.
   typedef enum logic [1:0] {
      ROW_PREDICT,
      ROW_ERROR,
      ROW_BAND
   } row_kind_type;

   typedef struct packed {
      fill_cmd_type cmd;
      row_kind_type kind;
      span_type     first;
   } fill_row_type;

   localparam int RAND_CMDS      = 360;
   localparam int WIND_DOWN_CMDS = 40;
   localparam int HOLD_AFTER     = 800;
   localparam int HOLD_CYCLES    = 400;
   localparam int DRAIN_CYCLES   = 20;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int REPORT_LIMIT   = 10;

   logic               clock             = 1'b0;
   logic               reset             = 1'b1;
   logic               req_push          = 1'b0;
   logic               req_full;
   logic [COORD_W-1:0] req_rect_x        = '0;
   logic [COORD_W-1:0] req_rect_y        = '0;
   logic [COORD_W-1:0] req_rect_w        = '0;
   logic [COORD_W-1:0] req_rect_h        = '0;
   logic [RAD_W-1:0]   req_corner_radius = '0;
   logic [COLOR_W-1:0] req_fill_color    = '0;
   logic               rsp_empty;
   logic               rsp_pop           = 1'b0;
   logic [COORD_W-1:0] rsp_span_x;
   logic [COORD_W-1:0] rsp_span_y;
   logic [COORD_W-1:0] rsp_span_w;
   logic [COORD_W-1:0] rsp_span_h;
   logic [COLOR_W-1:0] rsp_span_color;
   logic               rsp_last;
   logic               rsp_bad_shape;

   // Spans still owed by the block, oldest first.
   span_type     pending_spans[$];
   fill_row_type fill_table[$];
   int           mismatches   = 0;
   int           idle_cycles  = 0;
   // Set for the closing stretch of the run: no idling on either side.
   bit           wind_down    = 1'b0;

   rounded_rect_fill_spans u_top (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_rect_x        (req_rect_x),
      .req_rect_y        (req_rect_y),
      .req_rect_w        (req_rect_w),
      .req_rect_h        (req_rect_h),
      .req_corner_radius (req_corner_radius),
      .req_fill_color    (req_fill_color),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_span_x        (rsp_span_x),
      .rsp_span_y        (rsp_span_y),
      .rsp_span_w        (rsp_span_w),
      .rsp_span_h        (rsp_span_h),
      .rsp_span_color    (rsp_span_color),
      .rsp_last          (rsp_last),
      .rsp_bad_shape     (rsp_bad_shape)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Work out every span that one accepted command paints and queue them in
   // order. With drop_band set, the middle band is left out because the
   // table already typed it in; a rejected shape is then fully typed too.
   function automatic void predict_fill(input fill_cmd_type c, input bit drop_band);
      int       x, y, w, h, r;
      int       xl, yu, yb, wm, px, py, dec, a, b, k;
      bit       done;
      span_type s;
      x = int'(c.x);
      y = int'(c.y);
      w = int'(c.w);
      h = int'(c.h);
      r = int'(c.r);
      // Reject oversize radius, shapes that leave the grid, and a bottom arc
      // row above the top of the grid.
      if (r > MAX_RADIUS || w < 2 * r || h < 2 * r || x >= GRID || y >= GRID ||
          x + w > GRID || y + h > GRID || y + h - r - 1 < 0) begin
         if (!drop_band) begin
            s = '0;
            s.last = 1'b1;
            s.bad = 1'b1;
            pending_spans.push_back(s);
         end
         return;
      end
      s = '0;
      s.color = c.color;
      if (!drop_band) begin
         s.x = COORD_W'(x);
         s.y = COORD_W'(y + r);
         s.w = COORD_W'(w);
         s.h = COORD_W'(h - 2 * r);
         pending_spans.push_back(s);
      end
      xl = x + r;
      yu = y + r;
      yb = y + h - r - 1;
      wm = w - 2 * r;
      px = 0;
      py = r;
      dec = 1 - r;
      // Emit the start point group, then one group per midpoint step; the
      // step updates the decision value from px and py as they were.
      forever begin
         done = (px >= py);
         for (k = 0; k < 4; k++) begin
            a = (k < 2) ? py : px;
            b = (k < 2) ? px : py;
            s.x = COORD_W'(xl - a);
            s.y = (k % 2 == 0) ? COORD_W'(yu - b) : COORD_W'(yb + b);
            s.w = COORD_W'(wm + 2 * a);
            s.h = COORD_W'(1);
            s.last = done && (k == 3);
            pending_spans.push_back(s);
         end
         if (done) break;
         if (dec < 0) begin
            dec = dec + 2 * px + 1;
         end else begin
            dec = dec + 2 * (px - py) + 1;
            py = py - 1;
         end
         px = px + 1;
      end
   endfunction

   function automatic void add_row(input int x, input int y, input int w, input int h,
                                   input int r, input logic [COLOR_W-1:0] color,
                                   input row_kind_type kind, input int ex_x, input int ex_y,
                                   input int ex_w, input int ex_h);
      fill_row_type row;
      row.cmd.x = COORD_W'(x);
      row.cmd.y = COORD_W'(y);
      row.cmd.w = COORD_W'(w);
      row.cmd.h = COORD_W'(h);
      row.cmd.r = RAD_W'(r);
      row.cmd.color = color;
      row.kind = kind;
      row.first.x = COORD_W'(ex_x);
      row.first.y = COORD_W'(ex_y);
      row.first.w = COORD_W'(ex_w);
      row.first.h = COORD_W'(ex_h);
      row.first.color = (kind == ROW_BAND) ? color : '0;
      row.first.last = (kind == ROW_ERROR);
      row.first.bad = (kind == ROW_ERROR);
      fill_table.push_back(row);
   endfunction

   // Mostly well formed shapes with random content; the rest is raw noise,
   // which lands off the grid most of the time.
   function automatic fill_cmd_type random_cmd();
      fill_cmd_type c;
      int           r, w, h;
      c.color = $urandom;
      if ($urandom_range(0, 99) < 15) begin
         c.x = COORD_W'($urandom_range(0, 4095));
         c.y = COORD_W'($urandom_range(0, 4095));
         c.w = COORD_W'($urandom_range(0, 4095));
         c.h = COORD_W'($urandom_range(0, 4095));
         c.r = RAD_W'($urandom_range(0, MAX_RADIUS));
         return c;
      end
      r = ($urandom_range(0, 3) == 0) ? MAX_RADIUS : $urandom_range(0, MAX_RADIUS);
      w = ($urandom_range(0, 4) == 0) ? $urandom_range(2 * r, 4095)
                                      : 2 * r + $urandom_range(0, 40);
      h = ($urandom_range(0, 4) == 0) ? $urandom_range(2 * r, 4095)
                                      : 2 * r + $urandom_range(0, 40);
      c.r = RAD_W'(r);
      c.w = COORD_W'(w);
      c.h = COORD_W'(h);
      c.x = COORD_W'($urandom_range(0, GRID - w));
      c.y = COORD_W'($urandom_range(0, GRID - h));
      return c;
   endfunction

   // Offer one command and hold it until the block takes it; queue what it
   // should paint at the edge of the transfer.
   task automatic send_cmd(input fill_cmd_type c, input row_kind_type kind,
                           input span_type first);
      req_rect_x <= c.x;
      req_rect_y <= c.y;
      req_rect_w <= c.w;
      req_rect_h <= c.h;
      req_corner_radius <= c.r;
      req_fill_color <= c.color;
      req_push <= 1'b1;
      do @(posedge clock); while (req_full !== 1'b0);
      if (kind == ROW_PREDICT) begin
         predict_fill(c, 1'b0);
      end else begin
         pending_spans.push_back(first);
         predict_fill(c, 1'b1);
      end
   endtask

   // Drop push for a random burst now and then, except in the closing stretch.
   task automatic sender_gap();
      if (!wind_down && $urandom_range(0, 3) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   endtask

   task automatic report_mismatch(input string what, input span_type want,
                                  input span_type got);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
         $display("%s: expected x=%0d y=%0d w=%0d h=%0d color=%h last=%b bad=%b",
                  what, want.x, want.y, want.w, want.h, want.color, want.last, want.bad);
         $display("   got      x=%0d y=%0d w=%0d h=%0d color=%h last=%b bad=%b",
                  got.x, got.y, got.w, got.h, got.color, got.last, got.bad);
      end
   endtask

   // Command side: reset, the directed table, random commands, then drain.
   initial begin : cmd_source
      int       idx;
      span_type none;
      none = '0;
      // Rejected shapes: bottom row above the grid, off the right and bottom
      // edges, radius too large for the width and for the height.
      add_row(0, 0, 0, 0, 0, 32'h1234_5678, ROW_ERROR, 0, 0, 0, 0);
      add_row(2, 0, 4095, 10, 0, 32'hFFFF_FFFF, ROW_ERROR, 0, 0, 0, 0);
      add_row(0, 4000, 10, 97, 0, 32'hA5A5_A5A5, ROW_ERROR, 0, 0, 0, 0);
      add_row(10, 10, 29, 40, 15, 32'h0F0F_0F0F, ROW_ERROR, 0, 0, 0, 0);
      add_row(10, 10, 40, 29, 15, 32'hF0F0_F0F0, ROW_ERROR, 0, 0, 0, 0);
      add_row(4094, 20, 3, 3, 1, 32'h5555_AAAA, ROW_ERROR, 0, 0, 0, 0);
      // Grid extremes and empty bands; the middle band is typed in.
      add_row(0, 1, 0, 0, 0, 32'h0000_0000, ROW_BAND, 0, 1, 0, 0);
      add_row(4095, 4095, 1, 1, 0, 32'hFFFF_FFFF, ROW_BAND, 4095, 4095, 1, 1);
      add_row(0, 0, 4095, 4095, 15, 32'hFFFF_FFFF, ROW_BAND, 0, 15, 4095, 4065);
      add_row(1, 0, 4095, 10, 0, 32'h8000_0001, ROW_BAND, 1, 0, 4095, 10);
      add_row(100, 200, 50, 30, 15, 32'hDEAD_BEEF, ROW_BAND, 100, 215, 50, 0);
      add_row(300, 300, 30, 60, 15, 32'h0BAD_F00D, ROW_BAND, 300, 315, 30, 30);
      add_row(50, 60, 30, 30, 15, 32'h7FFF_FFFE, ROW_BAND, 50, 75, 30, 0);
      add_row(4066, 4066, 30, 30, 15, 32'h0000_0000, ROW_BAND, 4066, 4081, 30, 0);
      add_row(4095, 0, 0, 1, 0, 32'h3C3C_3C3C, ROW_BAND, 4095, 0, 0, 1);
      // Further radii from 1 to 12, checked against the span model.
      add_row(5, 5, 10, 10, 1, 32'h1111_1111, ROW_PREDICT, 0, 0, 0, 0);
      add_row(20, 30, 4, 4, 2, 32'h2222_2222, ROW_PREDICT, 0, 0, 0, 0);
      add_row(1000, 2000, 40, 17, 3, 32'h3333_3333, ROW_PREDICT, 0, 0, 0, 0);
      add_row(2048, 1024, 9, 100, 4, 32'h4444_4444, ROW_PREDICT, 0, 0, 0, 0);
      add_row(3000, 700, 64, 64, 7, 32'h7777_7777, ROW_PREDICT, 0, 0, 0, 0);
      add_row(123, 456, 18, 18, 9, 32'h9999_9999, ROW_PREDICT, 0, 0, 0, 0);
      add_row(2900, 3900, 100, 25, 12, 32'hCCCC_CCCC, ROW_PREDICT, 0, 0, 0, 0);

      // Hold reset at the start, then release it.
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (fill_table[i]) begin
         send_cmd(fill_table[i].cmd, fill_table[i].kind, fill_table[i].first);
         sender_gap();
      end
      for (idx = 0; idx < RAND_CMDS; idx++) begin
         if (idx >= RAND_CMDS - WIND_DOWN_CMDS) wind_down = 1'b1;
         send_cmd(random_cmd(), ROW_PREDICT, none);
         sender_gap();
      end
      req_push <= 1'b0;

      // Wait out every owed span, then watch a while for strays.
      while (pending_spans.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Span side: check each transfer against the oldest owed span, and pace
   // pop with random stall bursts plus one long hold-off that fills the
   // block up and pushes back on the command side.
   initial begin : span_sink
      int       spans_seen;
      int       stall_left;
      int       hold_left;
      bit       held;
      span_type got;
      span_type want;
      spans_seen = 0;
      stall_left = 0;
      hold_left = 0;
      held = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_pop && !rsp_empty) begin
            spans_seen++;
            got = {rsp_span_x, rsp_span_y, rsp_span_w, rsp_span_h, rsp_span_color,
                   rsp_last, rsp_bad_shape};
            if (pending_spans.size() == 0) begin
               report_mismatch("unexpected span", '0, got);
            end else begin
               want = pending_spans.pop_front();
               if (got !== want) report_mismatch("span mismatch", want, got);
            end
         end
         if (!held && spans_seen >= HOLD_AFTER) begin
            held = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_pop <= 1'b0;
         end else if (!wind_down && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 16) - 1;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   // Watchdog: end the run once no transfer has happened on either side for
   // far longer than the longest correct stall.
   always @(posedge clock) begin
      if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
